[hdl/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, off while reset is low
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// concurrent check sampled on the rising clock, always on
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[hdl/dslc_pkg.sv]
// shared types and constants of the dac sweep level calibrator
`default_nettype none

package dslc_pkg;

  localparam int ConverterBits = 12;
  localparam int MaxLevels     = 64;

  localparam int CodeW  = ConverterBits;
  localparam int LevelW = $clog2(MaxLevels);
  localparam int CountW = 7;
  localparam int GoalW  = CodeW + LevelW;
  localparam int TickW  = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxLevels);

  typedef enum logic {
    MODE_START  = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_CODE   = 3'd0,
    CFG_END_CODE     = 3'd1,
    CFG_STEP_COUNT   = 3'd2,
    CFG_SPACING      = 3'd3,
    CFG_SETTLE_HIT   = 3'd4,
    CFG_SETTLE_SRCH  = 3'd5,
    CFG_SETTLE_START = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CodeW-1:0]  start_code;
    logic [CodeW-1:0]  end_code;
    logic [CountW-1:0] step_count;
    logic [CodeW-1:0]  spacing;
    logic [TickW-1:0]  settle_hit;
    logic [TickW-1:0]  settle_srch;
    logic [TickW-1:0]  settle_start;
  } cfg_t;

  typedef struct packed {
    mode_e            mode;
    logic             channel;
    logic [CodeW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic              dac_write;
    logic [CodeW-1:0]  next_code;
    logic [TickW-1:0]  wait_ticks;
    logic              entry_valid;
    logic [LevelW-1:0] entry_step;
    logic [CodeW-1:0]  entry_code;
    logic [CodeW-1:0]  entry_reading;
    logic              finished;
    logic              active_channel;
  } result_t;

endpackage

`default_nettype wire

[hdl/dslc_cfg_regs.sv]
// configuration register file with reset defaults
`default_nettype none

module dslc_cfg_regs
  import dslc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code   <= CodeW'(1800);
      cfg_q.end_code     <= CodeW'(2500);
      cfg_q.step_count   <= CountW'(32);
      cfg_q.spacing      <= CodeW'(128);
      cfg_q.settle_hit   <= TickW'(150);
      cfg_q.settle_srch  <= TickW'(10);
      cfg_q.settle_start <= TickW'(2000);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_START_CODE:   cfg_q.start_code   <= cfg_wdata_i[CodeW-1:0];
        CFG_END_CODE:     cfg_q.end_code     <= cfg_wdata_i[CodeW-1:0];
        CFG_STEP_COUNT:   cfg_q.step_count   <= cfg_wdata_i[CountW-1:0];
        CFG_SPACING:      cfg_q.spacing      <= cfg_wdata_i[CodeW-1:0];
        CFG_SETTLE_HIT:   cfg_q.settle_hit   <= cfg_wdata_i[TickW-1:0];
        CFG_SETTLE_SRCH:  cfg_q.settle_srch  <= cfg_wdata_i[TickW-1:0];
        CFG_SETTLE_START: cfg_q.settle_start <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/dslc_sweep_core.sv]
// sweep state registers and the per-beat crossing and step logic
`default_nettype none

module dslc_sweep_core
  import dslc_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      fire_i,
  input  item_t    item_i,
  input  cfg_t     cfg_i,
  output result_t  res_o
);

  logic              running_q, running_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [GoalW-1:0]  goal_q, goal_d;
  logic [CodeW-1:0]  prev_q, prev_d;
  logic              chan_q, chan_d;

  logic [GoalW-1:0]  prev_ext, curr_ext, prev_diff, curr_diff, goal_prod;
  logic [CountW-1:0] level_nxt, eff_count;
  logic [CodeW-1:0]  code_inc;
  logic              hit, advance, step_on;
  result_t           res;

  always_comb begin
    prev_ext  = GoalW'(prev_q);
    curr_ext  = GoalW'(item_i.sample);
    hit       = (prev_ext <= goal_q) && (curr_ext >= goal_q);
    prev_diff = goal_q - prev_ext;
    curr_diff = curr_ext - goal_q;
    level_nxt = CountW'(level_q) + CountW'(1);
    eff_count = (cfg_i.step_count > MaxCount) ? MaxCount : cfg_i.step_count;
    advance   = hit && (level_nxt < eff_count);
    step_on   = (!hit || advance) && (code_q < cfg_i.end_code);
    code_inc  = code_q + CodeW'(1);
    goal_prod = {{(GoalW-LevelW){1'b0}}, level_nxt[LevelW-1:0]}
              * {{LevelW{1'b0}}, cfg_i.spacing};

    running_d = running_q;
    code_d    = code_q;
    level_d   = level_q;
    goal_d    = goal_q;
    prev_d    = prev_q;
    chan_d    = chan_q;

    res                = '0;
    res.next_code      = code_q;
    res.active_channel = chan_q;

    if (item_i.mode == MODE_START) begin
      running_d          = 1'b1;
      level_d            = LevelW'(1);
      code_d             = cfg_i.start_code;
      goal_d             = GoalW'(cfg_i.spacing);
      prev_d             = '0;
      chan_d             = item_i.channel;
      res.dac_write      = 1'b1;
      res.next_code      = cfg_i.start_code;
      res.wait_ticks     = cfg_i.settle_start;
      res.active_channel = item_i.channel;
    end else if (running_q) begin
      if (hit) begin
        res.entry_valid = 1'b1;
        res.entry_step  = level_q;
        if (prev_diff > curr_diff) begin
          res.entry_code    = (code_q == '0) ? '0 : code_q - CodeW'(1);
          res.entry_reading = prev_q;
        end else begin
          res.entry_code    = code_q;
          res.entry_reading = item_i.sample;
        end
      end
      if (advance) begin
        level_d = level_nxt[LevelW-1:0];
        goal_d  = goal_prod;
      end
      if (step_on) begin
        code_d         = code_inc;
        res.dac_write  = 1'b1;
        res.next_code  = code_inc;
        res.wait_ticks = advance ? cfg_i.settle_hit : cfg_i.settle_srch;
      end else begin
        running_d    = 1'b0;
        res.finished = 1'b1;
      end
      prev_d = item_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      code_q    <= '0;
      level_q   <= LevelW'(1);
      goal_q    <= '0;
      prev_q    <= '0;
      chan_q    <= 1'b0;
    end else if (fire_i) begin
      running_q <= running_d;
      code_q    <= code_d;
      level_q   <= level_d;
      goal_q    <= goal_d;
      prev_q    <= prev_d;
      chan_q    <= chan_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

[hdl/dac_sweep_level_calibrator_unit.sv]
// top level of the dac sweep level calibrator
// an accepted input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while the output is not stalled, set by the combinational sweep step
// between the input register and the result register
// reset: configuration returns to its defaults, the sweep is idle, no beat pending
`default_nettype none

module dac_sweep_level_calibrator_unit
  import dslc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 mode_i,
  input  wire                 channel_i,
  input  wire [CodeW-1:0]     sample_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                dac_write_o,
  output logic [CodeW-1:0]    next_code_o,
  output logic [TickW-1:0]    wait_ticks_o,
  output logic                entry_valid_o,
  output logic [LevelW-1:0]   entry_step_o,
  output logic [CodeW-1:0]    entry_code_o,
  output logic [CodeW-1:0]    entry_reading_o,
  output logic                finished_o,
  output logic                active_channel_o
);

  cfg_t    cfg;
  item_t   item_q;
  result_t res, res_q;
  logic    item_valid_q, out_valid_q;
  logic    in_fire, step_go;

  dslc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign step_go    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || step_go;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_valid_q <= 1'b1;
      end else if (step_go) begin
        item_valid_q <= 1'b0;
      end
      if (step_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode    <= mode_e'(mode_i);
      item_q.channel <= channel_i;
      item_q.sample  <= sample_i;
    end
    if (step_go) begin
      res_q <= res;
    end
  end

  dslc_sweep_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (step_go),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign dac_write_o      = res_q.dac_write;
  assign next_code_o      = res_q.next_code;
  assign wait_ticks_o     = res_q.wait_ticks;
  assign entry_valid_o    = res_q.entry_valid;
  assign entry_step_o     = res_q.entry_step;
  assign entry_code_o     = res_q.entry_code;
  assign entry_reading_o  = res_q.entry_reading;
  assign finished_o       = res_q.finished;
  assign active_channel_o = res_q.active_channel;

endmodule

`default_nettype wire

[hdl/dslc_checker.sv]
// port-level checker for the calibrator and its bind to the top level
`default_nettype none
`include "assert_macros.svh"

module dslc_checker
  import dslc_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input wire                 dac_write_o,
  input wire [CodeW-1:0]     next_code_o,
  input wire [TickW-1:0]     wait_ticks_o,
  input wire                 entry_valid_o,
  input wire [LevelW-1:0]    entry_step_o,
  input wire [CodeW-1:0]     entry_code_o,
  input wire [CodeW-1:0]     entry_reading_o,
  input wire                 finished_o
);

  // a stalled result beat stays valid and holds its next code and entry code
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni,
               out_valid_o && !out_ready_i |=>
               out_valid_o && $stable(next_code_o) && $stable(entry_code_o))
  // a finished sweep never asks for a dac write
  `ASSERT_CLKD(a_fin_no_write, clk_i, rst_ni, out_valid_o && finished_o |-> !dac_write_o)
  // no dac write means no settle delay
  `ASSERT_CLKD(a_idle_no_wait, clk_i, rst_ni, out_valid_o && !dac_write_o |-> wait_ticks_o == '0)
  // entry fields are clear without an entry
  `ASSERT_CLKD(a_entry_clear, clk_i, rst_ni,
               out_valid_o && !entry_valid_o |->
               entry_step_o == '0 && entry_code_o == '0 && entry_reading_o == '0)
  // a reported entry never belongs to level zero
  `ASSERT_CLKD(a_entry_step, clk_i, rst_ni, out_valid_o && entry_valid_o |-> entry_step_o != '0)

endmodule

bind dac_sweep_level_calibrator_unit dslc_checker u_dslc_checker (.*);

`default_nettype wire
